// File: hw/rtl/nand_flash_page_model_macros.svh
// Assertion macros shared by the checking code of the flash page model.
`ifndef NAND_FLASH_PAGE_MODEL_MACROS_SVH
`define NAND_FLASH_PAGE_MODEL_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define NFPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define NFPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/nfpm_pkg.sv
// Shared types, widths and codes of the flash page model.
package nfpm_pkg;

    localparam int DEF_MAX_BANKS   = 8;
    localparam int DEF_MAX_BLOCKS  = 64;
    localparam int DEF_MAX_PAGES   = 64;
    localparam int DEF_DATA_WIDTH  = 32;
    localparam int DEF_SPARE_WIDTH = 32;

    localparam int OP_W      = 2;
    localparam int BANK_W    = 3;
    localparam int BLOCK_W   = 6;
    localparam int PAGE_W    = 6;
    localparam int WORD_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int BCNT_W    = 4;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 7;

    // op(2) bank(3) block(6) page(6) data(32) spare(32) = 81 -> 88
    localparam int S_TDATA_W = 88;
    // status(3) data(32) spare(32) = 67 -> 72
    localparam int M_TDATA_W = 72;

    localparam logic [BCNT_W-1:0] RST_BANK_COUNT  = 4'd8;
    localparam logic [CNT_W-1:0]  RST_BLOCK_COUNT = 7'd64;
    localparam logic [CNT_W-1:0]  RST_PAGE_COUNT  = 7'd64;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_INVALID   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OVERWRITE = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_POSITION  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_READ    = 2'd0,
        OP_PROGRAM = 2'd1,
        OP_ERASE   = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BANK_COUNT  = 2'd0,
        CFG_BLOCK_COUNT = 2'd1,
        CFG_PAGE_COUNT  = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic capture;   // latch the incoming request
        logic clr_step;  // clear one row of written bits
        logic exec;      // evaluate, update stores, load result
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_done;  // clearing pass is on its last row
        logic out_free;  // result register can take a new result
    } t_dp_status;

endpackage

// File: hw/rtl/nfpm_ram.sv
// Generic simple dual-port RAM with registered read.
module nfpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/nfpm_ctrl.sv
// Controller state machine: clearing pass, request capture, lookup, execute.
module nfpm_ctrl
    import nfpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    output logic       o_req_ready,
    input  t_dp_status i_sts,
    output t_ctrl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_req_ready      = 1'b0;
        o_cmd.capture    = 1'b0;
        o_cmd.clr_step   = 1'b0;
        o_cmd.exec       = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
            end
            S_EXEC: begin
                o_cmd.exec = i_sts.out_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/nfpm_dp.sv
// Datapath: config registers, page stores, checks and the result register.
module nfpm_dp
    import nfpm_pkg::*;
#(
    parameter int MAX_BANKS   = DEF_MAX_BANKS,
    parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
    parameter int MAX_PAGES   = DEF_MAX_PAGES,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH,
    parameter int SPARE_WIDTH = DEF_SPARE_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0]    i_cfg_data,
    input  logic [OP_W-1:0]      i_op,
    input  logic [BANK_W-1:0]    i_bank,
    input  logic [BLOCK_W-1:0]   i_block,
    input  logic [PAGE_W-1:0]    i_page,
    input  logic [WORD_W-1:0]    i_write_data,
    input  logic [WORD_W-1:0]    i_write_spare,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [STATUS_W-1:0]  o_status,
    output logic [WORD_W-1:0]    o_read_data,
    output logic [WORD_W-1:0]    o_read_spare,
    input  t_ctrl_cmd            i_cmd,
    output t_dp_status           o_sts
);

    localparam int ROWS       = MAX_BANKS * MAX_BLOCKS;
    localparam int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOTS      = ROWS * MAX_PAGES;
    localparam int SLOT_AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PG_AW      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int BNK_STRIDE = MAX_BLOCKS * MAX_PAGES;

    // configuration registers
    logic [BCNT_W-1:0] r_bank_cnt;
    logic [CNT_W-1:0]  r_block_cnt;
    logic [CNT_W-1:0]  r_page_cnt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_cnt  <= RST_BANK_COUNT;
            r_block_cnt <= RST_BLOCK_COUNT;
            r_page_cnt  <= RST_PAGE_COUNT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BANK_COUNT:  r_bank_cnt  <= i_cfg_data[BCNT_W-1:0];
                CFG_BLOCK_COUNT: r_block_cnt <= i_cfg_data;
                CFG_PAGE_COUNT:  r_page_cnt  <= i_cfg_data;
                default: begin
                    r_bank_cnt <= r_bank_cnt;
                end
            endcase
        end
    end

    // captured request
    logic [OP_W-1:0]    r_op;
    logic [BANK_W-1:0]  r_bank;
    logic [BLOCK_W-1:0] r_block;
    logic [PAGE_W-1:0]  r_page;
    logic [PG_AW-1:0]   r_pidx;
    logic [ROW_AW-1:0]  r_row;
    logic [SLOT_AW-1:0] r_slot;
    logic [WORD_W-1:0]  r_wdata;
    logic [WORD_W-1:0]  r_wspare;
    logic               r_blk_ok;
    logic               r_page_ok;

    logic [31:0] w_row_full;
    logic [31:0] w_slot_full;
    logic        w_blk_ok;

    always_comb begin
        w_row_full  = 32'(i_bank) * 32'(MAX_BLOCKS) + 32'(i_block);
        w_slot_full = 32'(i_bank) * 32'(BNK_STRIDE) + 32'(i_block) * 32'(MAX_PAGES)
                      + 32'(i_page);
        w_blk_ok    = ({1'b0, i_bank} < r_bank_cnt) && (32'(i_bank) < 32'(MAX_BANKS))
                      && ({1'b0, i_block} < r_block_cnt)
                      && (32'(i_block) < 32'(MAX_BLOCKS));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_op;
            r_bank    <= i_bank;
            r_block   <= i_block;
            r_page    <= i_page;
            r_pidx    <= PG_AW'(i_page);
            r_row     <= ROW_AW'(w_row_full);
            r_slot    <= SLOT_AW'(w_slot_full);
            r_wdata   <= i_write_data;
            r_wspare  <= i_write_spare;
            r_blk_ok  <= w_blk_ok;
            r_page_ok <= w_blk_ok && ({1'b0, i_page} < r_page_cnt)
                         && (32'(i_page) < 32'(MAX_PAGES));
        end
    end

    // clearing pass over the written-bit rows
    logic [ROW_AW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_cnt <= r_clr_cnt + ROW_AW'(1);
        end
    end

    assign o_sts.clr_done = (r_clr_cnt == ROW_AW'(ROWS - 1));
    assign o_sts.out_free = !o_out_valid || i_out_ready;

    // stores
    logic [MAX_PAGES-1:0]   w_row_rd;
    logic [MAX_PAGES-1:0]   w_row_wr;
    logic [ROW_AW-1:0]      w_row_waddr;
    logic                   w_row_we;
    logic [DATA_WIDTH-1:0]  w_data_rd;
    logic [SPARE_WIDTH-1:0] w_spare_rd;
    logic                   w_prog_we;
    logic                   w_erase_we;

    nfpm_ram #(.WIDTH(MAX_PAGES), .DEPTH(ROWS)) u_written (
        .i_clk   (i_clk),
        .i_we    (w_row_we),
        .i_waddr (w_row_waddr),
        .i_wdata (w_row_wr),
        .i_raddr (r_row),
        .o_rdata (w_row_rd)
    );

    nfpm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS)) u_data (
        .i_clk   (i_clk),
        .i_we    (w_prog_we),
        .i_waddr (r_slot),
        .i_wdata (DATA_WIDTH'(r_wdata)),
        .i_raddr (r_slot),
        .o_rdata (w_data_rd)
    );

    nfpm_ram #(.WIDTH(SPARE_WIDTH), .DEPTH(SLOTS)) u_spare (
        .i_clk   (i_clk),
        .i_we    (w_prog_we),
        .i_waddr (r_slot),
        .i_wdata (SPARE_WIDTH'(r_wspare)),
        .i_raddr (r_slot),
        .o_rdata (w_spare_rd)
    );

    // evaluation
    logic [MAX_PAGES-1:0] w_mask;
    logic                 w_cur;
    logic                 w_prev;
    logic                 w_any;
    logic                 w_seq_err;
    logic [STATUS_W-1:0]  w_status;
    logic                 w_rd_ok;
    logic                 w_lp_clear;
    logic                 w_prog_ok;
    logic                 w_erase_ok;

    logic                 r_lp_valid;
    logic [BANK_W-1:0]    r_lp_bank;
    logic [BLOCK_W-1:0]   r_lp_block;
    logic [PAGE_W-1:0]    r_lp_page;

    always_comb begin
        for (int i = 0; i < MAX_PAGES; i++) begin
            w_mask[i] = (32'(i) < 32'(r_page_cnt));
        end
        w_cur     = w_row_rd[r_pidx];
        w_prev    = (r_pidx == '0) ? 1'b1 : w_row_rd[r_pidx - PG_AW'(1)];
        w_any     = |(w_row_rd & w_mask);
        w_seq_err = r_lp_valid && (r_lp_bank == r_bank) && (r_lp_block == r_block)
                    && (({1'b0, r_lp_page} + 7'd1) != {1'b0, r_page});
    end

    always_comb begin
        w_status   = STAT_INVALID;
        w_rd_ok    = 1'b0;
        w_lp_clear = 1'b0;
        w_prog_ok  = 1'b0;
        w_erase_ok = 1'b0;
        case (r_op)
            OP_READ: begin
                if (r_page_ok) begin
                    w_lp_clear = 1'b1;
                    if (w_cur) begin
                        w_status = STAT_OK;
                        w_rd_ok  = 1'b1;
                    end else begin
                        w_status = STAT_EMPTY;
                    end
                end
            end
            OP_PROGRAM: begin
                if (r_page_ok) begin
                    if (w_cur) begin
                        w_status = STAT_OVERWRITE;
                    end else if (w_seq_err || !w_prev) begin
                        w_status = STAT_POSITION;
                    end else begin
                        w_status  = STAT_OK;
                        w_prog_ok = 1'b1;
                    end
                end
            end
            OP_ERASE: begin
                w_lp_clear = 1'b1;
                if (r_blk_ok) begin
                    if (w_any) begin
                        w_status   = STAT_OK;
                        w_erase_ok = 1'b1;
                    end else begin
                        w_status = STAT_EMPTY;
                    end
                end
            end
            default: begin
                w_status = STAT_INVALID;
            end
        endcase
    end

    assign w_prog_we  = i_cmd.exec && w_prog_ok;
    assign w_erase_we = i_cmd.exec && w_erase_ok;

    always_comb begin
        w_row_we    = i_cmd.clr_step || w_prog_we || w_erase_we;
        w_row_waddr = i_cmd.clr_step ? r_clr_cnt : r_row;
        if (i_cmd.clr_step) begin
            w_row_wr = '0;
        end else if (w_erase_ok) begin
            w_row_wr = w_row_rd & ~w_mask;
        end else begin
            w_row_wr = w_row_rd | (MAX_PAGES'(1) << r_pidx);
        end
    end

    // last-program record
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp_valid <= 1'b0;
            r_lp_bank  <= '0;
            r_lp_block <= '0;
            r_lp_page  <= '0;
        end else if (w_prog_we) begin
            r_lp_valid <= 1'b1;
            r_lp_bank  <= r_bank;
            r_lp_block <= r_block;
            r_lp_page  <= r_page;
        end else if (i_cmd.exec && w_lp_clear) begin
            r_lp_valid <= 1'b0;
        end
    end

    // result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [WORD_W-1:0]   r_rdata;
    logic [WORD_W-1:0]   r_rspare;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= w_status;
            r_rdata  <= w_rd_ok ? WORD_W'(w_data_rd) : '0;
            r_rspare <= w_rd_ok ? WORD_W'(w_spare_rd) : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_data  = r_rdata;
    assign o_read_spare = r_rspare;

endmodule

// File: hw/rtl/nand_flash_page_model.sv
// Top level of the NAND flash page model: ports, packing, controller and datapath.
//
// Usage:
//   Requests enter on the s_t* stream (read, page program or block erase at
//   a bank/block/page address); each gives exactly one result on the m_t*
//   stream with a status word and, on a successful read, the data and spare
//   words. Registers (bank, block and page counts) are written on the cfg
//   channel, which is always ready; write them only while the block is idle.
// Request flow:
//   Each request is accepted, looked up (registered RAM read) and executed;
//   the next is taken only after it has executed. The result is valid the
//   cycle after execute; the written-bit row read-modify-write is done there.
// Reset:
//   After reset the block clears its written-bit rows, one row per cycle, all
//   MAX_BANKS * MAX_BLOCKS of them (512 at defaults); s_tready stays low then.
//   Count registers return to 8, 64 and 64.
// Stall:
//   A result waits in the output register while m_tready is low; a new
//   request may be accepted and looked up meanwhile, and execution holds
//   until the output register frees.
`include "nand_flash_page_model_macros.svh"

module nand_flash_page_model
    import nfpm_pkg::*;
#(
    parameter int MAX_BANKS   = DEF_MAX_BANKS,
    parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
    parameter int MAX_PAGES   = DEF_MAX_PAGES,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH,
    parameter int SPARE_WIDTH = DEF_SPARE_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0]    i_cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // op[1:0], bank[4:2], block[10:5], page[16:11], write_data[48:17],
    // write_spare[80:49], zero fill[87:81]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[2:0], read_data[34:3], read_spare[66:35], zero fill[71:67]
    output logic [M_TDATA_W-1:0] m_tdata
);

    t_ctrl_cmd           w_cmd;
    t_dp_status          w_sts;
    logic [STATUS_W-1:0] w_status;
    logic [WORD_W-1:0]   w_read_data;
    logic [WORD_W-1:0]   w_read_spare;

    // Hold the request handshake in the controller; the datapath sees commands only.
    nfpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_tvalid),
        .o_req_ready (s_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Unpack the request fields straight from tdata.
    nfpm_dp #(
        .MAX_BANKS   (MAX_BANKS),
        .MAX_BLOCKS  (MAX_BLOCKS),
        .MAX_PAGES   (MAX_PAGES),
        .DATA_WIDTH  (DATA_WIDTH),
        .SPARE_WIDTH (SPARE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_op          (s_tdata[1:0]),
        .i_bank        (s_tdata[4:2]),
        .i_block       (s_tdata[10:5]),
        .i_page        (s_tdata[16:11]),
        .i_write_data  (s_tdata[48:17]),
        .i_write_spare (s_tdata[80:49]),
        .i_out_ready   (m_tready),
        .o_out_valid   (m_tvalid),
        .o_status      (w_status),
        .o_read_data   (w_read_data),
        .o_read_spare  (w_read_spare),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts)
    );

    // Pack the result, zero-filling up to a whole byte.
    assign m_tdata = {5'd0, w_read_spare, w_read_data, w_status};

    // A request is taken only between results: no second accept right behind one.
    `NFPM_ASSERT_NEXT(a_single_request, s_tvalid && s_tready, !s_tready,
        "request accepted while previous one is still in flight")

    // No request enters while the written-bit rows are being cleared.
    `NFPM_ASSERT_NOW(a_no_accept_in_clear, w_cmd.clr_step, !s_tready,
        "request port ready during clearing pass")

    // Execution only fires when the result register can take the result.
    `NFPM_ASSERT_NOW(a_exec_needs_room, w_cmd.exec, w_sts.out_free,
        "execute issued while a result is still pending")

    // Every execute leaves a valid result behind.
    `NFPM_ASSERT_NEXT(a_exec_gives_result, w_cmd.exec, m_tvalid,
        "execute did not produce a result")

endmodule
